// File: sv/lss_pkg.sv
// Shared types and constants for the linear system solver.
// Used by the front end, the command queue, the divider, the solve engine and the top level.
package lss_pkg;

  localparam int MAX_UNKNOWNS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int DATA_W        = 32;
  localparam int SIZE_W        = 5;
  localparam int OUT_IDX_W     = 4;
  localparam int N_W           = $clog2(MAX_UNKNOWNS + 1);
  localparam int IDX_W         = $clog2(MAX_UNKNOWNS);
  localparam int ROW_STRIDE    = MAX_UNKNOWNS + 1;
  localparam int MAT_DEPTH     = MAX_UNKNOWNS * ROW_STRIDE;
  localparam int ADDR_W        = $clog2(MAT_DEPTH);
  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH    = MAX_UNKNOWNS;
  localparam int RESQ_PTR_W    = $clog2(RESQ_DEPTH);

  // One classified matrix entry on its way to the solve engine.
  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } cmd_t;

  // One solution component on its way out.
  typedef struct packed {
    logic [OUT_IDX_W-1:0]     idx;
    logic signed [DATA_W-1:0] value;
    logic                     singular;
    logic                     last;
  } res_t;

  function automatic logic [ADDR_W-1:0] mat_addr(logic [IDX_W-1:0] row, logic [N_W-1:0] col);
    return ADDR_W'(row * ROW_STRIDE) + ADDR_W'(col);
  endfunction

endpackage

// File: sv/lss_front.sv
// Front end: holds the size register, counts loaded entries and tags each
// entry with its matrix address and an end-of-matrix mark. Uses lss_pkg.
module lss_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lss_pkg::SIZE_W-1:0]       size_in_use_i,
  input  logic                             push_i,
  input  logic signed [lss_pkg::DATA_W-1:0] entry_value_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output lss_pkg::cmd_t                    q_cmd_o,
  output logic [lss_pkg::N_W-1:0]          n_o
);

  logic [lss_pkg::SIZE_W-1:0] size_q, size_d;
  logic [lss_pkg::IDX_W-1:0]  row_q, row_d;
  logic [lss_pkg::N_W-1:0]    col_q, col_d;
  logic [lss_pkg::N_W-1:0]    n;
  logic                       accept, last;

  always_comb begin
    if (size_q == '0) begin
      n = lss_pkg::N_W'(1);
    end else if (int'(size_q) > lss_pkg::MAX_UNKNOWNS) begin
      n = lss_pkg::N_W'(lss_pkg::MAX_UNKNOWNS);
    end else begin
      n = lss_pkg::N_W'(size_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !q_full_i;
  assign last        = (lss_pkg::N_W'(row_q) == n - lss_pkg::N_W'(1)) && (col_q == n);

  always_comb begin
    size_d = size_q;
    row_d  = row_q;
    col_d  = col_q;
    if (cfg_valid_i) begin
      size_d = size_in_use_i;
      row_d  = '0;
      col_d  = '0;
    end else if (accept) begin
      if (last) begin
        row_d = '0;
        col_d = '0;
      end else if (col_q == n) begin
        row_d = row_q + lss_pkg::IDX_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + lss_pkg::N_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= lss_pkg::SIZE_W'(lss_pkg::MAX_UNKNOWNS);
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      size_q <= size_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  assign q_push_o      = accept;
  assign q_cmd_o.addr  = lss_pkg::mat_addr(row_q, col_q);
  assign q_cmd_o.value = entry_value_i;
  assign q_cmd_o.last  = last;
  assign n_o           = n;

endmodule

// File: sv/lss_cmd_queue.sv
// Short queue of tagged entries between the front end and the solve engine.
// Uses lss_pkg.
module lss_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lss_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lss_pkg::cmd_t data_o
);

  lss_pkg::cmd_t                    buf_q [lss_pkg::CMDQ_DEPTH];
  logic [lss_pkg::CMDQ_PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lss_pkg::CMDQ_PTR_W:0]     cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == (lss_pkg::CMDQ_PTR_W + 1)'(lss_pkg::CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + lss_pkg::CMDQ_PTR_W'(1) : wptr_q;
    rptr_d = do_pop  ? rptr_q + lss_pkg::CMDQ_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + (lss_pkg::CMDQ_PTR_W + 1)'(do_push) - (lss_pkg::CMDQ_PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: sv/lss_div.sv
// Fixed-point divider: (num << FRACTION_BITS) / den, truncated toward zero and
// saturated, one quotient bit per cycle. Uses lss_pkg.
module lss_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [lss_pkg::DATA_W-1:0] num_i,
  input  logic signed [lss_pkg::DATA_W-1:0] den_i,
  output logic                              done_o,
  output logic signed [lss_pkg::DATA_W-1:0] quo_o
);

  localparam int DVD_W = lss_pkg::DATA_W + lss_pkg::FRACTION_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                         busy_q, fin_q, done_q, neg_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [lss_pkg::DATA_W-1:0]   rem_q, den_q, num_mag, den_mag;
  logic [DVD_W-1:0]             dvd_q;
  logic [lss_pkg::DATA_W:0]     trial;
  logic                         fits, ovf;
  logic signed [lss_pkg::DATA_W-1:0] quo_q, res;

  assign num_mag = num_i[lss_pkg::DATA_W-1] ? lss_pkg::DATA_W'(-num_i) : num_i;
  assign den_mag = den_i[lss_pkg::DATA_W-1] ? lss_pkg::DATA_W'(-den_i) : den_i;
  assign trial   = {rem_q, dvd_q[DVD_W-1]};
  assign fits    = (trial >= {1'b0, den_q});

  always_comb begin
    if (neg_q) begin
      ovf = (dvd_q[DVD_W-1:lss_pkg::DATA_W] != '0) ||
            (dvd_q[lss_pkg::DATA_W-1] && (dvd_q[lss_pkg::DATA_W-2:0] != '0));
      res = ovf ? {1'b1, {(lss_pkg::DATA_W-1){1'b0}}}
                : lss_pkg::DATA_W'(-dvd_q[lss_pkg::DATA_W-1:0]);
    end else begin
      ovf = (dvd_q[DVD_W-1:lss_pkg::DATA_W-1] != '0);
      res = ovf ? {1'b0, {(lss_pkg::DATA_W-1){1'b1}}} : dvd_q[lss_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_mag;
      neg_q <= num_i[lss_pkg::DATA_W-1] ^ den_i[lss_pkg::DATA_W-1];
      dvd_q <= {num_mag, {lss_pkg::FRACTION_BITS{1'b0}}};
    end else if (busy_q) begin
      rem_q <= fits ? lss_pkg::DATA_W'(trial - {1'b0, den_q}) : trial[lss_pkg::DATA_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
    if (fin_q) begin
      quo_q <= res;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: sv/lss_engine.sv
// Solve engine: stores the augmented matrix, runs forward elimination and
// back substitution with one shared multiplier and the external divider.
// Uses lss_pkg.
module lss_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [lss_pkg::N_W-1:0]           n_i,
  input  logic                              cmd_valid_i,
  input  lss_pkg::cmd_t                     cmd_i,
  output logic                              cmd_pop_o,
  output logic                              div_start_o,
  output logic signed [lss_pkg::DATA_W-1:0] div_num_o,
  output logic signed [lss_pkg::DATA_W-1:0] div_den_o,
  input  logic                              div_done_i,
  input  logic signed [lss_pkg::DATA_W-1:0] div_quo_i,
  input  logic                              res_full_i,
  output logic                              res_push_o,
  output lss_pkg::res_t                     res_o
);

  localparam int DW = lss_pkg::DATA_W;
  localparam int NW = lss_pkg::N_W;
  localparam int IW = lss_pkg::IDX_W;

  typedef enum logic [21:0] {
    ST_LOAD    = 22'h000001,
    ST_ROW_RD  = 22'h000002,
    ST_ROW_CAP = 22'h000004,
    ST_PIV     = 22'h000008,
    ST_L_RD    = 22'h000010,
    ST_L_CAP   = 22'h000020,
    ST_L_DIV   = 22'h000040,
    ST_U_RD    = 22'h000080,
    ST_U_CAP   = 22'h000100,
    ST_U_RND   = 22'h000200,
    ST_U_WR    = 22'h000400,
    ST_B_RD    = 22'h000800,
    ST_B_CAP   = 22'h001000,
    ST_P_RD    = 22'h002000,
    ST_P_CAP   = 22'h004000,
    ST_A_RD    = 22'h008000,
    ST_A_CAP   = 22'h010000,
    ST_A_RND   = 22'h020000,
    ST_A_SUB   = 22'h040000,
    ST_FIN     = 22'h080000,
    ST_X_DIV   = 22'h100000,
    ST_PUSH    = 22'h200000
  } state_e;

  function automatic logic signed [DW-1:0] rnd_sat(logic signed [2*DW-1:0] p);
    logic signed [2*DW-1:0] t;
    t = (p + ((2*DW)'(1) <<< (lss_pkg::FRACTION_BITS - 1))) >>> lss_pkg::FRACTION_BITS;
    if ((t[2*DW-1:DW-1] == '0) || (t[2*DW-1:DW-1] == '1)) begin
      return t[DW-1:0];
    end
    return t[2*DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  function automatic logic signed [DW-1:0] sub_sat(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
    logic [DW:0] d;
    d = {a[DW-1], a} - {b[DW-1], b};
    if (d[DW] == d[DW-1]) begin
      return d[DW-1:0];
    end
    return d[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  state_e state_q, state_d;
  logic [NW-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic          sing_q, sing_d;

  logic signed [DW-1:0]   mem [lss_pkg::MAT_DEPTH];
  logic signed [DW-1:0]   rdata_q;
  logic signed [DW-1:0]   prow_q [lss_pkg::MAX_UNKNOWNS + 1];
  logic signed [DW-1:0]   sol_q [lss_pkg::MAX_UNKNOWNS];
  logic signed [DW-1:0]   l_q, a_q, m_q, acc_q, piv_q, x_q;
  logic signed [2*DW-1:0] prod_q;
  logic signed [DW-1:0]   mul_a, mul_b;

  logic                         we;
  logic [lss_pkg::ADDR_W-1:0]   waddr, raddr;
  logic signed [DW-1:0]         wdata;
  logic                         prow_we, sol_we;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    sing_d      = sing_q;
    cmd_pop_o   = 1'b0;
    div_start_o = 1'b0;
    div_num_o   = rdata_q;
    div_den_o   = prow_q[k_q];
    res_push_o  = 1'b0;
    we          = 1'b0;
    waddr       = cmd_i.addr;
    wdata       = cmd_i.value;
    raddr       = '0;
    prow_we     = 1'b0;
    sol_we      = 1'b0;
    mul_a       = l_q;
    mul_b       = prow_q[j_q];
    unique case (state_q)
      ST_LOAD: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          we        = 1'b1;
          if (cmd_i.last) begin
            k_d     = '0;
            j_d     = '0;
            sing_d  = 1'b0;
            state_d = ST_ROW_RD;
          end
        end
      end
      // Cache the pivot row from the diagonal to the right-hand side.
      ST_ROW_RD: begin
        raddr   = lss_pkg::mat_addr(k_q[IW-1:0], j_q);
        state_d = ST_ROW_CAP;
      end
      ST_ROW_CAP: begin
        prow_we = 1'b1;
        if (j_q == n_i) begin
          state_d = ST_PIV;
        end else begin
          j_d     = j_q + NW'(1);
          state_d = ST_ROW_RD;
        end
      end
      ST_PIV: begin
        if (prow_q[k_q] != '0 && (k_q + NW'(1)) < n_i) begin
          i_d     = k_q + NW'(1);
          state_d = ST_L_RD;
        end else begin
          if (prow_q[k_q] == '0) begin
            sing_d = 1'b1;
          end
          if ((k_q + NW'(1)) < n_i) begin
            k_d     = k_q + NW'(1);
            j_d     = k_q + NW'(1);
            state_d = ST_ROW_RD;
          end else begin
            k_d     = n_i - NW'(1);
            state_d = ST_B_RD;
          end
        end
      end
      ST_L_RD: begin
        raddr   = lss_pkg::mat_addr(i_q[IW-1:0], k_q);
        state_d = ST_L_CAP;
      end
      ST_L_CAP: begin
        div_start_o = 1'b1;
        state_d     = ST_L_DIV;
      end
      ST_L_DIV: begin
        if (div_done_i) begin
          j_d     = k_q;
          state_d = ST_U_RD;
        end
      end
      ST_U_RD: begin
        raddr   = lss_pkg::mat_addr(i_q[IW-1:0], j_q);
        state_d = ST_U_CAP;
      end
      ST_U_CAP: state_d = ST_U_RND;
      ST_U_RND: state_d = ST_U_WR;
      ST_U_WR: begin
        we    = 1'b1;
        waddr = lss_pkg::mat_addr(i_q[IW-1:0], j_q);
        wdata = sub_sat(a_q, m_q);
        if (j_q != n_i) begin
          j_d     = j_q + NW'(1);
          state_d = ST_U_RD;
        end else if ((i_q + NW'(1)) < n_i) begin
          i_d     = i_q + NW'(1);
          state_d = ST_L_RD;
        end else begin
          // Next column: the last column never reaches here, it has no rows below.
          k_d     = k_q + NW'(1);
          j_d     = k_q + NW'(1);
          state_d = ST_ROW_RD;
        end
      end
      ST_B_RD: begin
        raddr   = lss_pkg::mat_addr(k_q[IW-1:0], n_i);
        state_d = ST_B_CAP;
      end
      ST_B_CAP: begin
        i_d     = k_q + NW'(1);
        state_d = ST_P_RD;
      end
      ST_P_RD: begin
        raddr   = lss_pkg::mat_addr(k_q[IW-1:0], k_q);
        state_d = ST_P_CAP;
      end
      ST_P_CAP: state_d = (i_q < n_i) ? ST_A_RD : ST_FIN;
      ST_A_RD: begin
        raddr   = lss_pkg::mat_addr(k_q[IW-1:0], i_q);
        state_d = ST_A_CAP;
      end
      ST_A_CAP: begin
        mul_a   = rdata_q;
        mul_b   = sol_q[i_q[IW-1:0]];
        state_d = ST_A_RND;
      end
      ST_A_RND: state_d = ST_A_SUB;
      ST_A_SUB: begin
        if ((i_q + NW'(1)) < n_i) begin
          i_d     = i_q + NW'(1);
          state_d = ST_A_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        div_num_o = acc_q;
        div_den_o = piv_q;
        if (piv_q == '0) begin
          sing_d  = 1'b1;
          state_d = ST_PUSH;
        end else begin
          div_start_o = 1'b1;
          state_d     = ST_X_DIV;
        end
      end
      ST_X_DIV: begin
        if (div_done_i) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          sol_we     = 1'b1;
          if (k_q == '0) begin
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q - NW'(1);
            state_d = ST_B_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign res_o.idx      = lss_pkg::OUT_IDX_W'(k_q);
  assign res_o.value    = x_q;
  assign res_o.singular = sing_q;
  assign res_o.last     = (k_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      sing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      sing_q  <= sing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prow_we) begin
      prow_q[j_q] <= rdata_q;
    end
    if (sol_we) begin
      sol_q[k_q[IW-1:0]] <= x_q;
    end
    if (state_q == ST_L_DIV && div_done_i) begin
      l_q <= div_quo_i;
    end
    if (state_q == ST_U_CAP) begin
      a_q <= rdata_q;
    end
    prod_q <= mul_a * mul_b;
    if (state_q == ST_U_RND || state_q == ST_A_RND) begin
      m_q <= rnd_sat(prod_q);
    end
    if (state_q == ST_B_CAP) begin
      acc_q <= rdata_q;
    end else if (state_q == ST_A_SUB) begin
      acc_q <= sub_sat(acc_q, m_q);
    end
    if (state_q == ST_P_CAP) begin
      piv_q <= rdata_q;
    end
    if (state_q == ST_FIN) begin
      x_q <= '0;
    end else if (state_q == ST_X_DIV && div_done_i) begin
      x_q <= div_quo_i;
    end
  end

endmodule

// File: sv/linear_system_solver.sv
// Top level of the linear system solver: front end, entry queue, solve engine,
// divider and result queue. Uses lss_pkg and all lss_* modules.
//
// Solves A x = b in signed Q16.16 by Gaussian elimination without pivoting and
// back substitution. Push n*(n+1) entries row by row (n coefficients, then b);
// after the last one the engine solves and queues x[n-1] down to x[0], index 0
// marked last. Entries of the next system are taken into a four-entry queue
// while a solve runs. While that queue has room, loading takes one entry per
// cycle. A solve does at most n^3/3 + n^2 - 4n/3 multiply-subtracts on the
// shared multiplier and at most n^2/2 + n/2 divisions in the bit-serial
// divider, and reads each pivot row from the matrix memory. Writing
// size_in_use restarts loading; write it only while the block is idle.
module linear_system_solver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lss_pkg::SIZE_W-1:0]        size_in_use_i,
  input  logic                              push,
  output logic                              full,
  input  logic signed [lss_pkg::DATA_W-1:0] entry_value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [lss_pkg::OUT_IDX_W-1:0]     unknown_index_o,
  output logic signed [lss_pkg::DATA_W-1:0] solution_value_o,
  output logic                              singular_o,
  output logic                              last_of_run_o
);

  lss_pkg::cmd_t              fe_cmd, q_cmd;
  logic                       fe_push, q_full, q_valid, q_pop;
  logic [lss_pkg::N_W-1:0]    n;
  logic                       div_start, div_done;
  logic signed [lss_pkg::DATA_W-1:0] div_num, div_den, div_quo;
  lss_pkg::res_t              res_in;
  logic                       res_push, res_full;

  lss_pkg::res_t                  rbuf_q [lss_pkg::RESQ_DEPTH];
  logic [lss_pkg::RESQ_PTR_W-1:0] rw_q, rr_q;
  logic [lss_pkg::RESQ_PTR_W:0]   rcnt_q, rcnt_d;
  logic                           r_pop;

  lss_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .size_in_use_i,
    .push_i(push), .entry_value_i, .q_full_i(q_full),
    .q_push_o(fe_push), .q_cmd_o(fe_cmd), .n_o(n)
  );

  lss_cmd_queue u_queue (
    .clk_i, .rst_ni, .push_i(fe_push), .data_i(fe_cmd), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_cmd)
  );

  lss_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  lss_engine u_engine (
    .clk_i, .rst_ni, .n_i(n), .cmd_valid_i(q_valid), .cmd_i(q_cmd),
    .cmd_pop_o(q_pop), .div_start_o(div_start), .div_num_o(div_num),
    .div_den_o(div_den), .div_done_i(div_done), .div_quo_i(div_quo),
    .res_full_i(res_full), .res_push_o(res_push), .res_o(res_in)
  );

  // Result queue holds one full run of solution beats.
  assign full     = q_full;
  assign res_full = (rcnt_q == (lss_pkg::RESQ_PTR_W + 1)'(lss_pkg::RESQ_DEPTH));
  assign empty    = (rcnt_q == '0);
  assign r_pop    = pop && !empty;
  assign rcnt_d   = rcnt_q + (lss_pkg::RESQ_PTR_W + 1)'(res_push)
                           - (lss_pkg::RESQ_PTR_W + 1)'(r_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q   <= '0;
      rr_q   <= '0;
      rcnt_q <= '0;
    end else begin
      if (res_push) begin
        rw_q <= rw_q + lss_pkg::RESQ_PTR_W'(1);
      end
      if (r_pop) begin
        rr_q <= rr_q + lss_pkg::RESQ_PTR_W'(1);
      end
      rcnt_q <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rbuf_q[rw_q] <= res_in;
    end
  end

  assign unknown_index_o  = rbuf_q[rr_q].idx;
  assign solution_value_o = rbuf_q[rr_q].value;
  assign singular_o       = rbuf_q[rr_q].singular;
  assign last_of_run_o    = rbuf_q[rr_q].last;

endmodule

// File: test/linear_system_solver_tb.sv
// Self-checking testbench for linear_system_solver: loads augmented matrices,
// predicts the solved vector in Q16.16 and checks every result beat.
// Depends on lss_pkg and the linear_system_solver RTL.
`timescale 1ns / 1ps

module linear_system_solver_tb;

  typedef struct packed {
    logic [lss_pkg::OUT_IDX_W-1:0]     idx;
    logic signed [lss_pkg::DATA_W-1:0] value;
    logic                              singular;
    logic                              last;
  } solution_t;

  localparam int SETTLE_CYCLES = 20000;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lss_pkg::SIZE_W-1:0]        cfg_size = '0;
  logic                              push = 1'b0;
  logic                              full;
  logic signed [lss_pkg::DATA_W-1:0] entry_value = '0;
  logic                              empty;
  logic                              pop = 1'b0;
  logic [lss_pkg::OUT_IDX_W-1:0]     unknown_index;
  logic signed [lss_pkg::DATA_W-1:0] solution_value;
  logic                              singular;
  logic                              last_of_run;

  // Predictor state
  logic signed [lss_pkg::DATA_W-1:0] mat [lss_pkg::MAX_UNKNOWNS][lss_pkg::ROW_STRIDE];
  logic signed [lss_pkg::DATA_W-1:0] xvec [lss_pkg::MAX_UNKNOWNS];
  int unsigned                       load_cnt = 0;
  logic [lss_pkg::SIZE_W-1:0]        size_reg = 5'd16;
  solution_t                         expected_solutions[$];

  int      error_count = 0;
  longint  cycle_count = 0;
  bit      stall_on = 1'b1;
  bit      long_stall = 1'b0;
  int      hold_off = 0;

  linear_system_solver u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .size_in_use_i   (cfg_size),
    .push            (push),
    .full            (full),
    .entry_value_i   (entry_value),
    .empty           (empty),
    .pop             (pop),
    .unknown_index_o (unknown_index),
    .solution_value_o(solution_value),
    .singular_o      (singular),
    .last_of_run_o   (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [lss_pkg::DATA_W-1:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[lss_pkg::DATA_W-1:0];
  endfunction

  function automatic logic signed [lss_pkg::DATA_W-1:0] q_mul(
      logic signed [lss_pkg::DATA_W-1:0] a, logic signed [lss_pkg::DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (lss_pkg::FRACTION_BITS - 1));
    return sat(p >>> lss_pkg::FRACTION_BITS);  // arithmetic shift floors
  endfunction

  function automatic logic signed [lss_pkg::DATA_W-1:0] q_div(
      logic signed [lss_pkg::DATA_W-1:0] num, logic signed [lss_pkg::DATA_W-1:0] den);
    longint nn;
    nn = longint'(num) * (64'sd1 <<< lss_pkg::FRACTION_BITS);
    return sat(nn / longint'(den));
  endfunction

  function automatic logic signed [lss_pkg::DATA_W-1:0] q_sub(
      logic signed [lss_pkg::DATA_W-1:0] a, logic signed [lss_pkg::DATA_W-1:0] b);
    return sat(longint'(a) - longint'(b));
  endfunction

  function automatic int active_n();
    if (size_reg == 0) return 1;
    if (size_reg > lss_pkg::MAX_UNKNOWNS) return lss_pkg::MAX_UNKNOWNS;
    return size_reg;
  endfunction

  // Load one entry; on the last entry eliminate, back-substitute and queue results.
  task automatic predict_entry(logic signed [lss_pkg::DATA_W-1:0] v);
    int n;
    int row;
    int col;
    bit sing;
    logic signed [lss_pkg::DATA_W-1:0] l;
    logic signed [lss_pkg::DATA_W-1:0] acc;
    solution_t s;
    n = active_n();
    if (load_cnt >= n * (n + 1)) load_cnt = 0;
    row = load_cnt / (n + 1);
    col = load_cnt % (n + 1);
    mat[row][col] = v;
    load_cnt++;
    if (load_cnt < n * (n + 1)) return;
    load_cnt = 0;
    sing = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (mat[k][k] == 0) begin
        sing = 1'b1;
        continue;
      end
      for (int i = k + 1; i < n; i++) begin
        l = q_div(mat[i][k], mat[k][k]);
        for (int j = k; j < n; j++) mat[i][j] = q_sub(mat[i][j], q_mul(l, mat[k][j]));
        mat[i][n] = q_sub(mat[i][n], q_mul(l, mat[k][n]));
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      acc = mat[k][n];
      for (int i = k + 1; i < n; i++) acc = q_sub(acc, q_mul(mat[k][i], xvec[i]));
      if (mat[k][k] == 0) begin
        sing = 1'b1;
        xvec[k] = '0;
      end else begin
        xvec[k] = q_div(acc, mat[k][k]);
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      s.idx = k[lss_pkg::OUT_IDX_W-1:0];
      s.value = xvec[k];
      s.singular = sing;
      s.last = (k == 0);
      expected_solutions.push_back(s);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic idle_cycles(int count);
    repeat (count) @(negedge clk);
  endtask

  // Offer one beat and hold it until accepted; push stays high for the next beat.
  task automatic send_entry(logic signed [lss_pkg::DATA_W-1:0] v);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      idle_cycles($urandom_range(1, 15));
    end
    push <= 1'b1;
    entry_value <= v;
    do @(posedge clk); while (full);
    predict_entry(v);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_solutions.size() != 0) @(negedge clk);
    idle_cycles(SETTLE_CYCLES);
  endtask

  task automatic write_size(logic [lss_pkg::SIZE_W-1:0] sz);
    cfg_valid <= 1'b1;
    cfg_size <= sz;
    do @(posedge clk); while (!cfg_ready);
    size_reg = sz;
    load_cnt = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [lss_pkg::DATA_W-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh80000000;
      2: return 32'sh7fffffff;
      3: return '0;
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  // Result checker with its own bursty hold-off.
  always @(posedge clk) begin
    if (pop && !empty) begin
      if (expected_solutions.size() == 0) begin
        report_mismatch("unexpected beat, index", unknown_index, -1);
      end else begin
        solution_t e;
        e = expected_solutions.pop_front();
        if (unknown_index !== e.idx) report_mismatch("unknown_index", unknown_index, e.idx);
        if (solution_value !== e.value)
          report_mismatch("solution_value", solution_value, e.value);
        if (singular !== e.singular) report_mismatch("singular", singular, e.singular);
        if (last_of_run !== e.last) report_mismatch("last_of_run", last_of_run, e.last);
      end
    end
  end

  always @(negedge clk) begin
    if (long_stall) begin
      pop <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(1, 15);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic test_extremes();
    write_size(5'd2);
    // Ordinary well-conditioned 2x2, then extremes of the entry field.
    send_entry(32'sh0002_0000); send_entry(32'sh0001_0000); send_entry(32'sh0003_0000);
    send_entry(32'sh0001_0000); send_entry(32'sh0003_0000); send_entry(32'sh0005_0000);
    send_entry(32'sh7fffffff); send_entry(32'sh80000000); send_entry(32'sh7fffffff);
    send_entry(32'sh80000000); send_entry(32'sh0000_0001); send_entry(32'shffffffff);
    wait_drained();
  endtask

  task automatic test_singular();
    write_size(5'd2);
    // Zero pivot in the first column, then a zero pivot only in the last column.
    send_entry('0); send_entry(32'sh0001_0000); send_entry(32'sh0001_0000);
    send_entry(32'sh0001_0000); send_entry(32'sh0001_0000); send_entry(32'sh0002_0000);
    send_entry(32'sh0001_0000); send_entry(32'sh0001_0000); send_entry(32'sh0001_0000);
    send_entry(32'sh0001_0000); send_entry(32'sh0001_0000); send_entry(32'sh0001_0000);
    wait_drained();
  endtask

  task automatic test_size_clamp();
    write_size(5'd0);  // treated as one unknown
    send_entry(32'sh0004_0000); send_entry(32'sh0002_0000);
    wait_drained();
    write_size(5'd31); // clamps to the largest system
    for (int i = 0; i < 16 * 17; i++) send_entry(i % 18 == 0 ? 32'sh0008_0000 : rand_entry());
    wait_drained();
  endtask

  task automatic test_restart();
    write_size(5'd3);
    repeat (5) send_entry(rand_entry());
    wait_drained();
    write_size(5'd3);  // drop the partial load
    repeat (12) send_entry(rand_entry());
    wait_drained();
  endtask

  // Hold the reader off while the sender keeps offering entries of many one-unknown systems.
  task automatic test_backpressure();
    write_size(5'd1);
    @(negedge clk);
    long_stall = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        long_stall = 1'b0;
      end
    join_none
    repeat (40) send_entry(rand_entry());
    wait_drained();
  endtask

  task automatic test_random();
    int n;
    int sent;
    sent = 0;
    while (sent < 40) begin
      if (sent > 20) stall_on = 1'b0;
      n = $urandom_range(1, 4);
      write_size(n[lss_pkg::SIZE_W-1:0]);
      repeat ($urandom_range(1, 2)) begin
        for (int r = 0; r < n; r++)
          for (int c = 0; c <= n; c++) begin
            // bias diagonal to be nonzero most of the time
            if (r == c && $urandom_range(0, 7) != 0)
              send_entry($signed($urandom_range(32'h0001_0000, 32'h0004_0000)));
            else
              send_entry(rand_entry());
            sent++;
          end
      end
      wait_drained();
    end
  endtask

  initial begin
    idle_cycles(11);
    rst_n <= 1'b1;
    idle_cycles(2);
    test_extremes();
    test_singular();
    test_size_clamp();
    test_restart();
    test_backpressure();
    test_random();
    wait_drained();
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
sv/lss_pkg.sv
sv/lss_front.sv
sv/lss_cmd_queue.sv
sv/lss_div.sv
sv/lss_engine.sv
sv/linear_system_solver.sv
test/linear_system_solver_tb.sv
